FILE: hdl/rws_pkg.sv
package rws_pkg;

    // Field widths of the request and result beats.
    localparam int OP_W      = 2;
    localparam int INDEX_W   = 6;
    localparam int VALUE_W   = 16;
    localparam int RAND_BITS = 16;
    localparam int POP_W     = 7;

    // Operation codes, echoed as the result kind.
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_SELECT  = 2'd1;
    localparam logic [OP_W-1:0] OP_FITTEST = 2'd2;

    // Population size after reset.
    localparam logic [POP_W-1:0] POP_RESET = 7'd64;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [INDEX_W-1:0]   entry_index;
        logic [VALUE_W-1:0]   fitness_value;
        logic [RAND_BITS-1:0] random_fraction;
    } rws_req_t;

    typedef struct packed {
        logic [OP_W-1:0]    result_kind;
        logic [INDEX_W-1:0] result_index;
        logic [VALUE_W-1:0] result_fitness;
    } rws_res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ld_in;
        logic mem_wr;
        logic rd_en;
        logic clr_cnt;
        logic inc_cnt;
        logic sum_acc;
        logic mul_init;
        logic mul_step;
        logic load_target;
        logic walk_step;
        logic fit_step;
        logic res_write;
        logic res_found;
        logic res_zero;
        logic res_best;
    } rws_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
        logic hit;
        logic mul_last;
    } rws_stat_t;

endpackage

FILE: hdl/rws_ctrl.sv
module rws_ctrl
    import rws_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [OP_W-1:0] op,
    input  rws_stat_t       status,
    output rws_cmd_t        cmd,
    output logic            busy,
    output logic            done
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_WRITE    = 4'd1;
    localparam logic [3:0] S_SUM_RD   = 4'd2;
    localparam logic [3:0] S_SUM_ACC  = 4'd3;
    localparam logic [3:0] S_MUL      = 4'd4;
    localparam logic [3:0] S_TARGET   = 4'd5;
    localparam logic [3:0] S_WALK_RD  = 4'd6;
    localparam logic [3:0] S_WALK_CMP = 4'd7;
    localparam logic [3:0] S_FIT_RD   = 4'd8;
    localparam logic [3:0] S_FIT_CMP  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       done_reg;
    logic       done_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.ld_in = 1'b1;
                    if (op == OP_WRITE)
                    begin
                        state_next = S_WRITE;
                    end
                    else if (op == OP_SELECT)
                    begin
                        cmd.clr_cnt = 1'b1;
                        state_next  = S_SUM_RD;
                    end
                    else if (op == OP_FITTEST)
                    begin
                        cmd.clr_cnt = 1'b1;
                        state_next  = S_FIT_RD;
                    end
                end
            end
            S_WRITE:
            begin
                cmd.mem_wr    = 1'b1;
                cmd.res_write = 1'b1;
                state_next    = S_IDLE;
            end
            S_SUM_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_SUM_ACC;
            end
            S_SUM_ACC:
            begin
                cmd.sum_acc = 1'b1;
                if (status.last)
                begin
                    cmd.mul_init = 1'b1;
                    state_next   = S_MUL;
                end
                else
                begin
                    cmd.inc_cnt = 1'b1;
                    state_next  = S_SUM_RD;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (status.mul_last)
                begin
                    state_next = S_TARGET;
                end
            end
            S_TARGET:
            begin
                cmd.load_target = 1'b1;
                cmd.clr_cnt     = 1'b1;
                state_next      = S_WALK_RD;
            end
            S_WALK_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_WALK_CMP;
            end
            S_WALK_CMP:
            begin
                if (status.hit)
                begin
                    cmd.res_found = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (status.last)
                begin
                    cmd.res_zero = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    cmd.inc_cnt   = 1'b1;
                    state_next    = S_WALK_RD;
                end
            end
            S_FIT_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_FIT_CMP;
            end
            S_FIT_CMP:
            begin
                cmd.fit_step = 1'b1;
                if (status.last)
                begin
                    cmd.res_best = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.inc_cnt = 1'b1;
                    state_next  = S_FIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The result strobe follows the cycle in which the result register loads.
    assign done_next = cmd.res_write | cmd.res_found | cmd.res_zero | cmd.res_best;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    // A result beat is never repeated in the following cycle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // A result beat is only shown once the operation has finished.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    // Work only starts from an accepted command.
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy raised without a start");

endmodule

FILE: hdl/rws_datapath.sv
module rws_datapath
    import rws_pkg::*;
#(
    parameter int MAX_POPULATION = 64,
    parameter int FITNESS_BITS   = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  rws_req_t         request,
    input  logic             cfg_wr,
    input  logic [POP_W-1:0] cfg_data,
    input  rws_cmd_t         cmd,
    output rws_stat_t        status,
    output rws_res_t         result
);

    localparam int FW     = FITNESS_BITS;
    localparam int ADDR_W = (MAX_POPULATION > 1) ? $clog2(MAX_POPULATION) : 1;
    localparam int SUM_W  = FW + ADDR_W;
    localparam int PROD_W = SUM_W + RAND_BITS;
    localparam int MCNT_W = $clog2(RAND_BITS);
    localparam int NW     = (ADDR_W + 1 > POP_W) ? ADDR_W + 1 : POP_W;

    logic [FW-1:0]        fit_mem [MAX_POPULATION];

    logic [POP_W-1:0]     pop_reg;
    logic [OP_W-1:0]      op_reg;
    logic [INDEX_W-1:0]   widx_reg;
    logic [VALUE_W-1:0]   wval_reg;
    logic [RAND_BITS-1:0] rand_reg;
    logic [ADDR_W-1:0]    cnt_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [PROD_W-1:0]    acc_next;
    logic [MCNT_W-1:0]    mcnt_reg;
    logic [SUM_W-1:0]     rem_reg;
    logic [FW-1:0]        best_reg;
    logic [ADDR_W-1:0]    where_reg;
    logic [FW-1:0]        rdata_reg;
    rws_res_t             result_reg;

    logic [NW-1:0]        pop_w;
    logic [NW-1:0]        n_eff;
    logic [ADDR_W-1:0]    last_idx;
    logic                 in_range;
    logic [FW-1:0]        wval_fw;
    logic                 ge;
    logic [SUM_W-1:0]     target;

    // Entries in use: zero counts as one, and the table depth caps it.
    assign pop_w = NW'(pop_reg);
    always_comb
    begin
        priority if (pop_w == '0)
        begin
            n_eff = NW'(1);
        end
        else if (pop_w > NW'(MAX_POPULATION))
        begin
            n_eff = NW'(MAX_POPULATION);
        end
        else
        begin
            n_eff = pop_w;
        end
    end
    assign last_idx = ADDR_W'(n_eff - NW'(1));

    assign in_range = (32'(widx_reg) < 32'(MAX_POPULATION));
    assign wval_fw  = FW'(wval_reg);
    assign ge       = (rdata_reg >= best_reg);
    assign target   = acc_reg[PROD_W-1:RAND_BITS];

    // Shift-add multiply, most significant random bit first.
    assign acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                    + (rand_reg[RAND_BITS-1] ? PROD_W'(sum_reg) : '0);

    assign status.last     = (cnt_reg == last_idx);
    assign status.hit      = (rem_reg < SUM_W'(rdata_reg));
    assign status.mul_last = (mcnt_reg == MCNT_W'(RAND_BITS - 1));

    // Population size register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_reg <= POP_RESET;
        end
        else if (cfg_wr)
        begin
            pop_reg <= cfg_data;
        end
    end

    // Fitness memory, one write and one registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr && in_range)
        begin
            fit_mem[ADDR_W'(widx_reg)] <= wval_fw;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= fit_mem[cnt_reg];
        end
    end

    // Operand capture, scan counter and accumulators.
    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            op_reg    <= request.op;
            widx_reg  <= request.entry_index;
            wval_reg  <= request.fitness_value;
            rand_reg  <= request.random_fraction;
            sum_reg   <= '0;
            best_reg  <= '0;
            where_reg <= '0;
        end
        if (cmd.clr_cnt)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.inc_cnt)
        begin
            cnt_reg <= cnt_reg + ADDR_W'(1);
        end
        if (cmd.sum_acc)
        begin
            sum_reg <= sum_reg + SUM_W'(rdata_reg);
        end
        if (cmd.mul_init)
        begin
            acc_reg  <= '0;
            mcnt_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            acc_reg  <= acc_next;
            mcnt_reg <= mcnt_reg + MCNT_W'(1);
            rand_reg <= {rand_reg[RAND_BITS-2:0], 1'b0};
        end
        if (cmd.load_target)
        begin
            rem_reg <= target;
        end
        else if (cmd.walk_step)
        begin
            rem_reg <= rem_reg - SUM_W'(rdata_reg);
        end
        if (cmd.fit_step && ge)
        begin
            best_reg  <= rdata_reg;
            where_reg <= cnt_reg;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.res_write)
        begin
            result_reg.result_kind    <= op_reg;
            result_reg.result_index   <= widx_reg;
            result_reg.result_fitness <= in_range ? VALUE_W'(wval_fw) : '0;
        end
        else if (cmd.res_found)
        begin
            result_reg.result_kind    <= op_reg;
            result_reg.result_index   <= INDEX_W'(cnt_reg);
            result_reg.result_fitness <= VALUE_W'(rdata_reg);
        end
        else if (cmd.res_zero)
        begin
            // Nothing qualified: every entry in use, entry 0 included, is zero.
            result_reg.result_kind    <= op_reg;
            result_reg.result_index   <= '0;
            result_reg.result_fitness <= '0;
        end
        else if (cmd.res_best)
        begin
            result_reg.result_kind    <= op_reg;
            result_reg.result_index   <= INDEX_W'(ge ? cnt_reg : where_reg);
            result_reg.result_fitness <= VALUE_W'(ge ? rdata_reg : best_reg);
        end
    end

    assign result = result_reg;

    // The fallback answer is only reached when the wheel is empty.
    a_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_zero |-> (sum_reg == '0))
        else $error("selection fell through with a non-zero sum");

    // The scaled target never exceeds the total.
    a_target_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_target |-> (target <= sum_reg))
        else $error("selection target above the fitness sum");

    // A selected entry always has a non-zero slice of the wheel.
    a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_found |-> (rdata_reg != '0))
        else $error("selection landed on a zero-fitness entry");

endmodule

FILE: hdl/roulette_wheel_selector.sv
// Roulette wheel selector: fitness proportionate parent selection.
// A command beat on request is taken at a clock edge with start high and busy
// low. Op write stores one fitness entry, op select draws a parent from the
// first population_size entries weighted by fitness, op fittest names the last
// entry holding the largest value. The unused op code is taken and dropped.
// Each write, select or fittest command gives one result beat on result, marked
// by done for exactly one cycle; the receiver cannot stall, so it must take the
// beat in that cycle. With n entries in use, fittest reads and compares each of
// the n entries in turn; select reads and sums all n entries, scales the sum
// by the random fraction, then reads entries from entry 0 up to the selected
// one. Every entry passes a read state and then a compare or accumulate state,
// as the single memory read port has a registered read, and the sum is scaled
// by a 16-step shift-add multiply, most significant random bit first.
// A new command is taken in the cycle its predecessor's result is shown.
// population_size is written over cfg_valid/cfg_data (ready is always high);
// the user must do this only while no command is in progress (not enforced).
// Reset sets population_size to 64 and idles the controller; the fitness
// memory is not cleared, and each entry must be written before it is used.
module roulette_wheel_selector
    import rws_pkg::*;
#(
    parameter int MAX_POPULATION = 64,
    parameter int FITNESS_BITS   = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  rws_req_t         request,
    output logic             done,
    output rws_res_t         result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [POP_W-1:0] cfg_data
);

    rws_cmd_t  cmd;
    rws_stat_t status;

    assign cfg_ready = 1'b1;

    // Controller.
    rws_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (request.op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Datapath with the fitness memory.
    rws_datapath #(
        .MAX_POPULATION (MAX_POPULATION),
        .FITNESS_BITS   (FITNESS_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cfg_wr   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .result   (result)
    );

endmodule
